FILE: rtl/spbc_pkg.sv
// Package for the swept point versus box collision core: widths, codes and pipeline types.
`timescale 1ns / 1ps
package spbc_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int MARGIN_W  = WORD_BITS - 1;

   // Relative positions and box sizes, with margin, fit this signed width.
   localparam int DIFF_W = WORD_BITS + 6;
   // Magnitude of a plane distance.
   localparam int MAG_W  = DIFF_W - 1;
   // Dividend and quotient width of the entry-time divider.
   localparam int NUM_W  = MAG_W + FRAC_BITS;
   // Divisor width: the magnitude of a velocity.
   localparam int DEN_W  = WORD_BITS;
   // Full product width and width of a coordinate at entry time.
   localparam int PROD_W = 2 * WORD_BITS;
   localparam int Q_W    = PROD_W - FRAC_BITS + 2;

   localparam logic [1:0] AXIS_NONE = 2'd0;
   localparam logic [1:0] AXIS_X    = 2'd1;
   localparam logic [1:0] AXIS_Y    = 2'd2;
   localparam logic [1:0] AXIS_Z    = 2'd3;
   localparam logic [2:0][1:0] AXIS_OF = {AXIS_Z, AXIS_Y, AXIS_X};

   localparam logic [WORD_BITS-1:0] TIME_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] TIME_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // Per-item data that travels beside the division.
   typedef struct packed {
      logic [2:0][DIFF_W-1:0]    rel;
      logic [2:0][DIFF_W-1:0]    size;
      logic [2:0][WORD_BITS-1:0] vel;
      logic [2:0]                move;
      logic [2:0]                enter;
      logic [2:0]                stop;
      logic [2:0]                neg;
      logic                      in_box;
   } side_type;

endpackage

FILE: rtl/swept_point_box_collision_core.sv
// Top level of the swept point versus axis-aligned box collision core.
`timescale 1ns / 1ps
// This core takes one request per clock cycle while req_stall is low: a box, a
// point and its velocity in signed Q16.16. It grows the box by csr_wr_data's
// margin on every side, reports whether the point starts strictly inside, then
// tests the X, Y and Z entry planes in order and returns the first axis hit and
// the last entry time computed (0 if none). All three axes are evaluated in
// parallel lanes; the entry time of each lane comes from a restoring divider
// that produces one quotient bit per pipeline stage. The pipeline holds 2 front
// stages, NUM_W = 53 divider stages, 3 back stages and the output register,
// 59 register stages in all. Sustained throughput is one request per cycle
// while req_stall is low. A response that is stalled waits in the output
// register while one further result is caught by a skid register; only when
// that skid register is full does the core raise req_stall.
module swept_point_box_collision_core
   import spbc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [MARGIN_W-1:0]         csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_box_min_x,
   input  logic signed [WORD_BITS-1:0] req_box_min_y,
   input  logic signed [WORD_BITS-1:0] req_box_min_z,
   input  logic signed [WORD_BITS-1:0] req_box_max_x,
   input  logic signed [WORD_BITS-1:0] req_box_max_y,
   input  logic signed [WORD_BITS-1:0] req_box_max_z,
   input  logic signed [WORD_BITS-1:0] req_pos_x,
   input  logic signed [WORD_BITS-1:0] req_pos_y,
   input  logic signed [WORD_BITS-1:0] req_pos_z,
   input  logic signed [WORD_BITS-1:0] req_vel_x,
   input  logic signed [WORD_BITS-1:0] req_vel_y,
   input  logic signed [WORD_BITS-1:0] req_vel_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_hit_axis,
   output logic signed [WORD_BITS-1:0] rsp_hit_time,
   output logic                        rsp_started_inside
);

   // Margin register; the user must write it only while the core is idle, the block does not enforce this.
   logic [MARGIN_W-1:0] margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= '0;
      end else if (csr_wr_en) begin
         margin_ff <= csr_wr_data;
      end
   end

   // The whole pipeline moves together; it freezes only when the skid register
   // already holds a result that the output register could not take.
   logic skid_valid_ff;
   logic advance;

   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // Stage 1: grown box, relative position, size and the inside test.
   logic [2:0][WORD_BITS-1:0] in_min, in_max, in_pos, in_vel;
   side_type                  s1_in;
   logic                      s1_valid_ff;
   side_type                  s1_ff;

   assign in_min = {req_box_min_z, req_box_min_y, req_box_min_x};
   assign in_max = {req_box_max_z, req_box_max_y, req_box_max_x};
   assign in_pos = {req_pos_z, req_pos_y, req_pos_x};
   assign in_vel = {req_vel_z, req_vel_y, req_vel_x};

   always_comb begin
      logic signed [DIFF_W-1:0] m;
      logic signed [DIFF_W-1:0] rel;
      logic signed [DIFF_W-1:0] size;
      s1_in = '0;
      s1_in.in_box = 1'b1;
      m = $signed(DIFF_W'(margin_ff));
      for (int a = 0; a < 3; a++) begin
         rel  = DIFF_W'($signed(in_pos[a])) - DIFF_W'($signed(in_min[a])) + m;
         size = DIFF_W'($signed(in_max[a])) - DIFF_W'($signed(in_min[a])) + m + m;
         s1_in.rel[a]  = rel;
         s1_in.size[a] = size;
         s1_in.vel[a]  = in_vel[a];
         if (!(rel > 0 && rel < size)) begin
            s1_in.in_box = 1'b0;
         end
      end
   end

   // Stage 2: per-axis entry decision, dividend and divisor magnitudes.
   side_type                  s2_in;
   logic [2:0][NUM_W-1:0]     num_in;
   logic [2:0][DEN_W-1:0]     den_in;
   logic                      s2_valid_ff;
   side_type                  s2_ff;
   logic [2:0][NUM_W-1:0]     num_ff;
   logic [2:0][DEN_W-1:0]     den_ff;

   always_comb begin
      logic signed [DIFF_W-1:0]  rel;
      logic signed [DIFF_W-1:0]  size;
      logic signed [DIFF_W:0]    twice;
      logic signed [DIFF_W-1:0]  gap;
      logic [DIFF_W-1:0]         mag;
      logic signed [WORD_BITS-1:0] v;
      logic                      up;
      s2_in = s1_ff;
      for (int a = 0; a < 3; a++) begin
         rel   = $signed(s1_ff.rel[a]);
         size  = $signed(s1_ff.size[a]);
         v     = $signed(s1_ff.vel[a]);
         twice = {rel, 1'b0};
         up    = (v > 0);
         s2_in.move[a] = (v != 0);
         if (up) begin
            s2_in.enter[a] = s1_ff.in_box ? (twice <= (DIFF_W+1)'(size)) : (rel <= 0);
            s2_in.stop[a]  = rel > size;
            gap = -rel;
         end else begin
            s2_in.enter[a] = s1_ff.in_box ? (twice >= (DIFF_W+1)'(size)) : (rel >= size);
            s2_in.stop[a]  = rel < 0;
            gap = size - rel;
         end
         mag = gap[DIFF_W-1] ? DIFF_W'(-gap) : DIFF_W'(gap);
         s2_in.neg[a] = gap[DIFF_W-1] ^ v[WORD_BITS-1];
         num_in[a] = {mag[MAG_W-1:0], {FRAC_BITS{1'b0}}};
         den_in[a] = v[WORD_BITS-1] ? DEN_W'(-v) : DEN_W'(v);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         num_ff <= num_in;
         den_ff <= den_in;
      end
   end

   // Entry-time division for all three axes.
   logic                  dv_valid;
   logic [2:0][NUM_W-1:0] dv_quo;
   side_type              dv_side;

   spbc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .in_side   (s2_ff),
      .out_valid (dv_valid),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Stage 3: apply the sign and saturate the entry time to the word range.
   logic [2:0][WORD_BITS-1:0] time_in;
   logic                      s3_valid_ff;
   side_type                  s3_ff;
   logic [2:0][WORD_BITS-1:0] time_ff;

   always_comb begin
      logic [NUM_W-1:0] q;
      for (int a = 0; a < 3; a++) begin
         q = dv_quo[a];
         if (!dv_side.neg[a]) begin
            time_in[a] = (|q[NUM_W-1:WORD_BITS-1]) ? TIME_MAX : q[WORD_BITS-1:0];
         end else if ((|q[NUM_W-1:WORD_BITS]) ||
                      (q[WORD_BITS-1] && (|q[WORD_BITS-2:0]))) begin
            time_in[a] = TIME_MIN;
         end else begin
            time_in[a] = WORD_BITS'(-q[WORD_BITS-1:0]);
         end
      end
   end

   // Stage 4: the point's travel on the two other axes at each entry time.
   logic [2:0][1:0][PROD_W-1:0] prod_in;
   logic                        s4_valid_ff;
   side_type                    s4_ff;
   logic [2:0][WORD_BITS-1:0]   time4_ff;
   logic [2:0][1:0][PROD_W-1:0] prod_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod_in[a][0] = PROD_W'($signed(s3_ff.vel[(a + 1) % 3]) * $signed(time_ff[a]));
         prod_in[a][1] = PROD_W'($signed(s3_ff.vel[(a + 2) % 3]) * $signed(time_ff[a]));
      end
   end

   // Stage 5: coordinates at entry time, rounded toward minus infinity, checked
   // strictly inside the box on both other axes.
   logic [2:0]                hit_in;
   logic                      s5_valid_ff;
   side_type                  s5_ff;
   logic [2:0]                hit_ff;
   logic [2:0][WORD_BITS-1:0] time5_ff;

   always_comb begin
      logic signed [Q_W-1:0] q;
      logic signed [Q_W-1:0] lim;
      logic [1:0]            ok;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 2; k++) begin
            q = Q_W'($signed(s4_ff.rel[(a + 1 + k) % 3])) +
                Q_W'($signed(prod_ff[a][k][PROD_W-1:FRAC_BITS]));
            lim = Q_W'($signed(s4_ff.size[(a + 1 + k) % 3]));
            ok[k] = (q > 0) && (q < lim);
         end
         hit_in[a] = ok[0] && ok[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= dv_valid;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff    <= dv_side;
         time_ff  <= time_in;
         s4_ff    <= s3_ff;
         time4_ff <= time_ff;
         prod_ff  <= prod_in;
         s5_ff    <= s4_ff;
         hit_ff   <= hit_in;
         time5_ff <= time4_ff;
      end
   end

   // Axis priority: X, then Y, then Z. An axis that enters records its time;
   // a point already past the box on a moving axis ends the search.
   logic [1:0]           axis_res;
   logic [WORD_BITS-1:0] time_res;

   always_comb begin
      logic done;
      axis_res = AXIS_NONE;
      time_res = '0;
      done     = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (!done && s5_ff.move[a]) begin
            if (s5_ff.enter[a]) begin
               time_res = time5_ff[a];
               if (hit_ff[a]) begin
                  axis_res = AXIS_OF[a];
                  done     = 1'b1;
               end
            end else if (s5_ff.stop[a]) begin
               done = 1'b1;
            end
         end
      end
   end

   // Output register and skid register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_axis_ff;
   logic [WORD_BITS-1:0] rsp_time_ff;
   logic                 rsp_inside_ff;
   logic                 skid_valid_in;
   logic [1:0]           skid_axis_ff;
   logic [WORD_BITS-1:0] skid_time_ff;
   logic                 skid_inside_ff;
   logic                 rsp_free;
   logic                 tail_move;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign tail_move = advance && s5_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_free) begin
         rsp_valid_in  = skid_valid_ff || tail_move;
         skid_valid_in = 1'b0;
      end else if (tail_move) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_axis_ff   <= skid_axis_ff;
            rsp_time_ff   <= skid_time_ff;
            rsp_inside_ff <= skid_inside_ff;
         end else begin
            rsp_axis_ff   <= axis_res;
            rsp_time_ff   <= time_res;
            rsp_inside_ff <= s5_ff.in_box;
         end
      end else if (tail_move) begin
         skid_axis_ff   <= axis_res;
         skid_time_ff   <= time_res;
         skid_inside_ff <= s5_ff.in_box;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit_axis       = rsp_axis_ff;
   assign rsp_hit_time       = rsp_time_ff;
   assign rsp_started_inside = rsp_inside_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_frozen_pipeline: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(s1_valid_ff) && $stable(s5_valid_ff))
      else $error("pipeline moved while skid register was full");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !skid_valid_ff && !s5_valid_ff |=> !rsp_valid_ff)
      else $error("response appeared with no result behind it");

endmodule

FILE: rtl/spbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes and sideband.
`timescale 1ns / 1ps
module spbc_div
   import spbc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [2:0][NUM_W-1:0]        in_num,
   input  logic [2:0][DEN_W-1:0]        in_den,
   input  side_type                     in_side,
   output logic                         out_valid,
   output logic [2:0][NUM_W-1:0]        out_quo,
   output side_type                     out_side
);

   logic [NUM_W-1:0]            valid_ff;
   logic [2:0][NUM_W-1:0]       numq_ff [NUM_W];
   logic [2:0][DEN_W-1:0]       rem_ff  [NUM_W];
   logic [2:0][DEN_W-1:0]       den_ff  [NUM_W];
   side_type                    side_ff [NUM_W];

   logic                        src_valid [NUM_W];
   logic [2:0][NUM_W-1:0]       src_numq  [NUM_W];
   logic [2:0][DEN_W-1:0]       src_rem   [NUM_W];
   logic [2:0][DEN_W-1:0]       src_den   [NUM_W];
   side_type                    src_side  [NUM_W];

   logic [2:0][NUM_W-1:0]       numq_in [NUM_W];
   logic [2:0][DEN_W-1:0]       rem_in  [NUM_W];

   genvar s;
   generate
      for (s = 0; s < NUM_W; s++) begin : g_src
         if (s == 0) begin : g_first
            assign src_valid[s] = in_valid;
            assign src_numq[s]  = in_num;
            assign src_rem[s]   = '0;
            assign src_den[s]   = in_den;
            assign src_side[s]  = in_side;
         end else begin : g_next
            assign src_valid[s] = valid_ff[s-1];
            assign src_numq[s]  = numq_ff[s-1];
            assign src_rem[s]   = rem_ff[s-1];
            assign src_den[s]   = den_ff[s-1];
            assign src_side[s]  = side_ff[s-1];
         end
      end
   endgenerate

   // Each stage brings down one dividend bit and shifts one quotient bit in.
   always_comb begin
      logic [DEN_W:0] partial;
      for (int i = 0; i < NUM_W; i++) begin
         for (int a = 0; a < 3; a++) begin
            partial = {src_rem[i][a], src_numq[i][a][NUM_W-1]};
            if (partial >= {1'b0, src_den[i][a]}) begin
               rem_in[i][a]  = DEN_W'(partial - {1'b0, src_den[i][a]});
               numq_in[i][a] = {src_numq[i][a][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[i][a]  = partial[DEN_W-1:0];
               numq_in[i][a] = {src_numq[i][a][NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         for (int i = 0; i < NUM_W; i++) begin
            valid_ff[i] <= src_valid[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NUM_W; i++) begin
            numq_ff[i] <= numq_in[i];
            rem_ff[i]  <= rem_in[i];
            den_ff[i]  <= src_den[i];
            side_ff[i] <= src_side[i];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = numq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid |->
         (den_ff[NUM_W-1][0] == '0 || rem_ff[NUM_W-1][0] < den_ff[NUM_W-1][0]) &&
         (den_ff[NUM_W-1][1] == '0 || rem_ff[NUM_W-1][1] < den_ff[NUM_W-1][1]) &&
         (den_ff[NUM_W-1][2] == '0 || rem_ff[NUM_W-1][2] < den_ff[NUM_W-1][2]))
      else $error("divider remainder not below divisor");

   a_hold_when_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("divider stage valid bits moved while frozen");

   a_enter_stage: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid |=> valid_ff[0])
      else $error("divider lost an entering request");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the swept point versus box collision core.
`timescale 1ns / 1ps
// The testbench drives requests into the core through the valid/stall handshake
// and predicts every response in SystemVerilog. It keeps its own copy of the
// margin register and computes the grown box, the inside flag, and the plane
// tests in the order X, Y, Z, all in 64-bit arithmetic.
// A checker process compares each accepted response, field by field, with the
// oldest prediction. Named test tasks run in turn from one initial block:
//   - directed corner cases,
//   - a sweep over margin settings,
//   - a long receiver hold-off that makes the core stall its input,
//   - a random run of mostly well-formed geometry.
// The margin register is written only while no response is outstanding.
module testbench
   import spbc_pkg::*;
();

   // One request: box corners, point position and velocity, indexed X, Y, Z.
   typedef struct packed {
      logic [2:0][WORD_BITS-1:0] bmin;
      logic [2:0][WORD_BITS-1:0] bmax;
      logic [2:0][WORD_BITS-1:0] pos;
      logic [2:0][WORD_BITS-1:0] vel;
   } geom_type;

   // One predicted response.
   typedef struct packed {
      logic [1:0]           axis;
      logic [WORD_BITS-1:0] t;
      logic                 in_box;
   } collision_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [MARGIN_W-1:0]  csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   geom_type             req_geom = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_hit_axis;
   logic [WORD_BITS-1:0] rsp_hit_time;
   logic                 rsp_started_inside;

   // Testbench copy of the margin register.
   longint               margin_shadow = 0;
   collision_type        pending_results[$];
   int                   err_count = 0;
   // When set, neither side inserts random idle cycles.
   bit                   steady_flow = 1'b0;
   // A request for a long receiver hold-off, picked up by the stall process.
   bit                   hold_request = 1'b0;
   int                   hold_cycles = 0;

   swept_point_box_collision_core uut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_box_min_x      (req_geom.bmin[0]),
      .req_box_min_y      (req_geom.bmin[1]),
      .req_box_min_z      (req_geom.bmin[2]),
      .req_box_max_x      (req_geom.bmax[0]),
      .req_box_max_y      (req_geom.bmax[1]),
      .req_box_max_z      (req_geom.bmax[2]),
      .req_pos_x          (req_geom.pos[0]),
      .req_pos_y          (req_geom.pos[1]),
      .req_pos_z          (req_geom.pos[2]),
      .req_vel_x          (req_geom.vel[0]),
      .req_vel_y          (req_geom.vel[1]),
      .req_vel_z          (req_geom.vel[2]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit_axis       (rsp_hit_axis),
      .rsp_hit_time       (rsp_hit_time),
      .rsp_started_inside (rsp_started_inside)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // A generous fixed limit on the whole run.
   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Saturate a value to the signed word range.
   function automatic longint sat_word(input longint v);
      longint hi;
      hi = (longint'(1) <<< (WORD_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // True when the coordinate on axis ax at time t lies strictly inside the box.
   function automatic bit lies_within(input longint rel[3], input longint size[3],
                                      input longint vel[3], input int ax,
                                      input longint t);
      longint q;
      q = rel[ax] + ((vel[ax] * t) >>> FRAC_BITS);
      return (q < size[ax]) && (q > 0);
   endfunction

   // Predict the response of the core for one request under the current margin.
   function automatic collision_type predict_collision(input geom_type g,
                                                       input longint margin);
      longint        rel[3], size[3], vel[3];
      longint        lo, hi, t, scale;
      bit            in_box, enter, done;
      int            a, b, c;
      collision_type r;
      scale  = longint'(1) <<< FRAC_BITS;
      in_box = 1'b1;
      t      = 0;
      done   = 1'b0;
      r.axis = AXIS_NONE;
      for (int i = 0; i < 3; i++) begin
         lo      = longint'($signed(g.bmin[i])) - margin;
         hi      = longint'($signed(g.bmax[i])) + margin;
         rel[i]  = longint'($signed(g.pos[i])) - lo;
         size[i] = hi - lo;
         vel[i]  = longint'($signed(g.vel[i]));
         if (!(rel[i] > 0 && rel[i] < size[i])) in_box = 1'b0;
      end
      for (a = 0; a < 3 && !done; a++) begin
         b = (a + 1) % 3;
         c = (a + 2) % 3;
         if (vel[a] != 0) begin
            // Inside the box, entry is accepted when the point lies in the half nearest the entry plane.
            if (vel[a] > 0)
               enter = in_box ? (2 * rel[a] <= size[a]) : (rel[a] <= 0);
            else
               enter = in_box ? (2 * rel[a] >= size[a]) : (rel[a] >= size[a]);
            if (enter) begin
               if (vel[a] > 0)
                  t = sat_word((-rel[a] * scale) / vel[a]);
               else
                  t = sat_word(((size[a] - rel[a]) * scale) / vel[a]);
               if (lies_within(rel, size, vel, b, t) && lies_within(rel, size, vel, c, t)) begin
                  r.axis = AXIS_OF[a];
                  done   = 1'b1;
               end
            end else if ((vel[a] > 0 && rel[a] > size[a]) ||
                         (vel[a] < 0 && rel[a] < 0)) begin
               // The point is already past the box on a moving axis.
               done = 1'b1;
            end
         end
      end
      r.t      = t[WORD_BITS-1:0];
      r.in_box = in_box;
      return r;
   endfunction

   // Offer one request, wait for it to be taken, then record its prediction.
   task automatic send_request(input geom_type g);
      req_valid <= 1'b1;
      req_geom  <= g;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), predict_collision(g, margin_shadow));
      while (!steady_flow && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Wait until every predicted response has been checked.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the margin register; the core must be idle.
   task automatic write_margin(input logic [MARGIN_W-1:0] m);
      drain();
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= m;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      margin_shadow  = longint'(m);
      @(posedge clock);
   endtask

   function automatic logic [WORD_BITS-1:0] rand_word;
      return $urandom;
   endfunction

   // Random geometry. Most items are a sane box with a point nearby and a
   // modest velocity, so that the plane tests are reached; the rest is noise.
   function automatic geom_type random_geom;
      geom_type g;
      longint   base, span, scale_sel;
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(99) < 20) begin
            g.bmin[i] = rand_word();
            g.bmax[i] = rand_word();
            g.pos[i]  = rand_word();
            g.vel[i]  = rand_word();
         end else begin
            scale_sel = $urandom_range(12, 28);
            span      = longint'($urandom_range(1, 1 << 12)) <<< (scale_sel - 12);
            base      = $signed(rand_word()) >>> $urandom_range(0, 6);
            g.bmin[i] = base[WORD_BITS-1:0];
            g.bmax[i] = WORD_BITS'(base + span);
            g.pos[i]  = WORD_BITS'(base + longint'($urandom_range(0, 4)) * span / 2
                        - span + $signed(rand_word()) % (span + 1));
            case ($urandom_range(3))
               0:       g.vel[i] = '0;
               1:       g.vel[i] = rand_word();
               default: g.vel[i] = ($signed(rand_word()) >>> $urandom_range(4, 20));
            endcase
         end
      end
      return g;
   endfunction

   function automatic geom_type make_geom(input longint mn, input longint mx,
                                          input longint px, input longint py,
                                          input longint pz, input longint vx,
                                          input longint vy, input longint vz);
      geom_type g;
      for (int i = 0; i < 3; i++) begin
         g.bmin[i] = mn[WORD_BITS-1:0];
         g.bmax[i] = mx[WORD_BITS-1:0];
      end
      g.pos = {pz[WORD_BITS-1:0], py[WORD_BITS-1:0], px[WORD_BITS-1:0]};
      g.vel = {vz[WORD_BITS-1:0], vy[WORD_BITS-1:0], vx[WORD_BITS-1:0]};
      return g;
   endfunction

   // Corner cases: each hit axis, both directions, already past the box,
   // resting inside, an inverted box, saturated times and extreme words.
   task automatic test_directed;
      geom_type g;
      longint   one;
      one = longint'(1) <<< FRAC_BITS;
      send_request(make_geom(0, 10 * one, -one, 5 * one, 5 * one, one, 0, 0));
      send_request(make_geom(0, 10 * one, 11 * one, 5 * one, 5 * one, -one, 0, 0));
      send_request(make_geom(0, 10 * one, 5 * one, -3 * one, 5 * one, 0, 2 * one, 0));
      send_request(make_geom(0, 10 * one, 5 * one, 5 * one, 20 * one, 0, 0, -4 * one));
      send_request(make_geom(0, 10 * one, 20 * one, 5 * one, 5 * one, one, one, one));
      send_request(make_geom(0, 10 * one, -9 * one, 5 * one, 5 * one, -one, 0, 0));
      send_request(make_geom(0, 10 * one, 2 * one, 3 * one, 4 * one, one, -one, one));
      send_request(make_geom(0, 10 * one, 8 * one, 7 * one, 6 * one, -one, one, -one));
      send_request(make_geom(0, 10 * one, 5 * one, 5 * one, 5 * one, 0, 0, 0));
      send_request(make_geom(10 * one, 0, 5 * one, 5 * one, 5 * one, one, one, one));
      send_request(make_geom(-64'sh8000_0000, 64'sh7FFF_FFFF, -64'sh8000_0000,
                             0, 0, 1, 0, 0));
      send_request(make_geom(-one, one, 64'sh7FFF_FFFF, 0, 0, -1, 0, 0));
      send_request(make_geom(-64'sh8000_0000, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                             64'sh7FFF_FFFF, 64'sh7FFF_FFFF, -64'sh8000_0000,
                             -64'sh8000_0000, -64'sh8000_0000));
      send_request(make_geom(0, 10 * one, -one, 20 * one, 5 * one, one, 0, 0));
      send_request(make_geom(0, 10 * one, 5 * one, 5 * one, 5 * one,
                             64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF));
      g.bmin = '0;
      g.bmax = '1;
      g.pos  = '1;
      g.vel  = '1;
      send_request(g);
      g      = '0;
      send_request(g);
   endtask

   // A few fixed boxes that the margin changes the outcome of.
   task automatic test_directed_short;
      longint one;
      one = longint'(1) <<< FRAC_BITS;
      send_request(make_geom(0, 4 * one, -one / 2, 2 * one, 2 * one, one, 0, 0));
      send_request(make_geom(0, 4 * one, 4 * one + 5, 2 * one, 2 * one, -one, 0, 0));
   endtask

   // Several margin settings, the extremes among them, each with random items.
   task automatic test_margin_sweep;
      logic [MARGIN_W-1:0] settings[5];
      settings = '{'0, MARGIN_W'(1 << FRAC_BITS), '1, MARGIN_W'(1),
                   MARGIN_W'($urandom)};
      foreach (settings[s]) begin
         write_margin(settings[s]);
         test_directed_short();
         repeat (30) send_request(random_geom());
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming,
   // so the pipeline fills and the core stalls its input.
   task automatic test_backpressure;
      steady_flow  = 1'b1;
      hold_request = 1'b1;
      repeat (120) send_request(random_geom());
      steady_flow  = 1'b0;
   endtask

   // The bulk random run, with one stretch without any idle cycles.
   task automatic test_random;
      write_margin(MARGIN_W'($urandom_range(0, 1 << 20)));
      for (int n = 0; n < 255; n++) begin
         steady_flow = (n >= 100 && n < 160);
         send_request(random_geom());
      end
      steady_flow = 1'b0;
   endtask

   // Receiver: random stalls, no stalls during steady flow, and a long hold
   // when one has been requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_cycles  = 400;
         rsp_stall   <= 1'b1;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else if (steady_flow) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 36);
      end
   end

   // Checker: every accepted response against the oldest prediction.
   always @(posedge clock) begin
      collision_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response axis=%0d time=%h inside=%0d", $time,
                     rsp_hit_axis, rsp_hit_time, rsp_started_inside);
            err_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_hit_axis !== exp_r.axis) begin
               $display("%0t: hit_axis expected %0d actual %0d", $time,
                        exp_r.axis, rsp_hit_axis);
               err_count++;
            end
            if (rsp_hit_time !== exp_r.t) begin
               $display("%0t: hit_time expected %h actual %h", $time,
                        exp_r.t, rsp_hit_time);
               err_count++;
            end
            if (rsp_started_inside !== exp_r.in_box) begin
               $display("%0t: started_inside expected %0d actual %0d", $time,
                        exp_r.in_box, rsp_started_inside);
               err_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_margin_sweep();
      test_backpressure();
      test_random();
      drain();
      repeat (70) @(posedge clock);
      if (err_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: swept_point_box_collision_core.f
rtl/spbc_pkg.sv
rtl/spbc_div.sv
rtl/swept_point_box_collision_core.sv
tb/testbench.sv
